// ----- hdl/hsfd_pkg.sv -----
// Package: shared types and constants of the serial frame decoder.
package hsfd_pkg;

	// Framing bytes
	localparam logic [7:0] START_BYTE = 8'h21;
	localparam logic [7:0] END_BYTE   = 8'h3B;
	localparam logic [7:0] CMD_BASE   = 8'h40;
	localparam logic [7:0] CMD_LAST   = 8'h45;

	// Gear code range carried in a respond frame
	localparam logic [7:0] GEAR_MIN = 8'h01;
	localparam logic [7:0] GEAR_MAX = 8'h05;

	// Bytes in a complete frame, start and end included
	localparam int unsigned FRAME_LENGTH = 6;

	// Command codes (command byte minus CMD_BASE)
	typedef enum logic [2:0] {
		CMD_RESPOND     = 3'd0,
		CMD_CALIBRATE   = 3'd1,
		CMD_LEFT        = 3'd2,
		CMD_RIGHT       = 3'd3,
		CMD_DIR         = 3'd4,
		CMD_TOUCH_RESET = 3'd5
	} cmd_t;

	// Persist request codes
	typedef enum logic [1:0] {
		SAVE_NONE  = 2'd0,
		SAVE_LEFT  = 2'd1,
		SAVE_RIGHT = 2'd2,
		SAVE_DIR   = 2'd3
	} save_t;

	// Frame completion event from the framer to the settings logic
	typedef struct packed {
		logic       done;
		logic [7:0] cmd_byte;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} frm_evt_t;

endpackage

// ----- hdl/helm_serial_frame_decoder.sv -----
// Top level: serial command frame decoder with stored helm settings.
//
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// Frames are 0x21, a command byte 0x40..0x45, three payload bytes and 0x3B.
// Output channel: one result beat per completed frame (out_valid/out_ready)
// carrying the command and every stored setting after that frame's update.
// Throughput: one byte per cycle; decode and setting update are a single
// combinational pass between the framer registers and the result register.
// The result is valid in the cycle after the end byte is accepted.
// Stall: while a result waits and out_ready is low, in_ready is low; when
// out_ready is high the result register is refilled in the same cycle, so
// bytes keep flowing back to back.
// Reset: no frame open, settings cleared, the stored side difference is one, and
// the output channel is empty.
module helm_serial_frame_decoder #(
	parameter int unsigned MAX_FRAME_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  command,
	output logic [4:0]  gear_lights,
	output logic        control_taken,
	output logic [7:0]  steer_status,
	output logic [15:0] left_limit,
	output logic [15:0] right_limit,
	output logic [15:0] side_difference,
	output logic [7:0]  direction,
	output logic [1:0]  save_request
);

	hsfd_pkg::frm_evt_t evt;
	logic               accept;

	// Stored settings
	logic [4:0]  gear_q;
	logic        taken_q;
	logic [7:0]  steer_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic [15:0] diff_q;
	logic [7:0]  dir_q;

	// Next settings
	logic [2:0]  cmd;
	logic [15:0] value;
	logic [4:0]  gear_n;
	logic        taken_n;
	logic [7:0]  steer_n;
	logic [15:0] left_n;
	logic [15:0] right_n;
	logic [15:0] abs_n;
	logic [15:0] diff_n;
	logic [7:0]  dir_n;
	logic [1:0]  save_n;
	logic        upd_diff;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	hsfd_framer #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(rx_byte),
		.evt    (evt)
	);

	// Apply a completed frame to the settings
	always_comb begin
		cmd      = 3'(evt.cmd_byte - hsfd_pkg::CMD_BASE);
		value    = {evt.b2, evt.b3};
		gear_n   = gear_q;
		taken_n  = taken_q;
		steer_n  = steer_q;
		left_n   = left_q;
		right_n  = right_q;
		dir_n    = dir_q;
		save_n   = hsfd_pkg::SAVE_NONE;
		upd_diff = 1'b0;
		case (cmd)
			hsfd_pkg::CMD_RESPOND: begin
				taken_n = evt.b4[0];
				if (evt.b4[0]) begin
					steer_n = evt.b3;
					if ((evt.b2 >= hsfd_pkg::GEAR_MIN) && (evt.b2 <= hsfd_pkg::GEAR_MAX)) begin
						gear_n = 5'(5'd1 << (evt.b2[2:0] - 3'd1));
					end
				end
			end
			hsfd_pkg::CMD_LEFT: begin
				left_n   = value;
				upd_diff = 1'b1;
				save_n   = hsfd_pkg::SAVE_LEFT;
			end
			hsfd_pkg::CMD_RIGHT: begin
				right_n  = value;
				upd_diff = 1'b1;
				save_n   = hsfd_pkg::SAVE_RIGHT;
			end
			hsfd_pkg::CMD_DIR: begin
				dir_n  = evt.b2;
				save_n = hsfd_pkg::SAVE_DIR;
			end
			default: begin
				save_n = hsfd_pkg::SAVE_NONE;
			end
		endcase
		abs_n = (left_n >= right_n) ? (left_n - right_n) : (right_n - left_n);
		if (!upd_diff) begin
			diff_n = diff_q;
		end else if (abs_n == 16'd0) begin
			diff_n = 16'd1;
		end else begin
			diff_n = abs_n;
		end
	end

	// Update settings on a completed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q  <= '0;
			taken_q <= 1'b0;
			steer_q <= '0;
			left_q  <= '0;
			right_q <= '0;
			diff_q  <= 16'd1;
			dir_q   <= '0;
		end else if (accept && evt.done) begin
			gear_q  <= gear_n;
			taken_q <= taken_n;
			steer_q <= steer_n;
			left_q  <= left_n;
			right_q <= right_n;
			diff_q  <= diff_n;
			dir_q   <= dir_n;
		end
	end

	// Hold or drop the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept && evt.done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (accept && evt.done) begin
			command         <= cmd;
			gear_lights     <= gear_n;
			control_taken   <= taken_n;
			steer_status    <= steer_n;
			left_limit      <= left_n;
			right_limit     <= right_n;
			side_difference <= diff_n;
			direction       <= dir_n;
			save_request    <= save_n;
		end
	end

`ifndef SYNTHESIS
	a_done_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && evt.done) |=> out_valid)
		else $error("completed frame produced no result beat");

	a_diff_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (side_difference != 16'd0))
		else $error("side difference reached zero");

	a_gear_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(gear_lights))
		else $error("gear lights not one-hot");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command <= hsfd_pkg::CMD_TOUCH_RESET))
		else $error("command code out of range");

	a_save_left: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (save_request == hsfd_pkg::SAVE_LEFT)) |->
			(command == hsfd_pkg::CMD_LEFT))
		else $error("left save request without left command");
`endif

endmodule

// ----- hdl/hsfd_framer.sv -----
// Framer: tracks frame position and captures the payload bytes of a frame.
module hsfd_framer #(
	parameter int unsigned MAX_FRAME_BYTES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output hsfd_pkg::frm_evt_t evt
);

	localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

	logic          in_frame_q;
	logic          len_ok_q;
	logic [CW-1:0] count_q;
	logic [7:0]    b1_q, b2_q, b3_q, b4_q;

	logic          start;
	logic          done;
	logic          active;
	logic [CW-1:0] pos;
	logic [CW-1:0] cnt_next;
	logic          cmd_ok;

	// Decode the incoming byte against the frame position
	always_comb begin
		start    = (rx_byte == hsfd_pkg::START_BYTE) && !in_frame_q;
		done     = (rx_byte == hsfd_pkg::END_BYTE) && in_frame_q && len_ok_q &&
		           (count_q == CW'(hsfd_pkg::FRAME_LENGTH - 1));
		active   = start || (in_frame_q && !done);
		pos      = start ? '0 : count_q;
		cnt_next = pos + CW'(1);
		cmd_ok   = (rx_byte >= hsfd_pkg::CMD_BASE) && (rx_byte <= hsfd_pkg::CMD_LAST);
	end

	// Advance the frame position; drop the frame when the store is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_ok_q   <= 1'b0;
			count_q    <= '0;
		end else if (accept) begin
			if (done) begin
				in_frame_q <= 1'b0;
				len_ok_q   <= 1'b0;
				count_q    <= '0;
			end else if (active) begin
				if (cnt_next == CW'(MAX_FRAME_BYTES)) begin
					in_frame_q <= 1'b0;
					len_ok_q   <= 1'b0;
					count_q    <= '0;
				end else begin
					in_frame_q <= 1'b1;
					count_q    <= cnt_next;
					if (cnt_next == CW'(2)) begin
						len_ok_q <= cmd_ok;
					end
				end
			end
		end
	end

	// Capture the command and payload bytes
	always_ff @(posedge clk) begin
		if (accept && active) begin
			if (pos == CW'(1)) b1_q <= rx_byte;
			if (pos == CW'(2)) b2_q <= rx_byte;
			if (pos == CW'(3)) b3_q <= rx_byte;
			if (pos == CW'(4)) b4_q <= rx_byte;
		end
	end

	assign evt.done     = done;
	assign evt.cmd_byte = b1_q;
	assign evt.b2       = b2_q;
	assign evt.b3       = b3_q;
	assign evt.b4       = b4_q;

endmodule

// ----- tb/helm_serial_frame_decoder_tb.sv -----
`timescale 1ns / 100ps
// Testbench: serial frame decoder driven with byte streams and checked against a local predictor.
module helm_serial_frame_decoder_tb;

	localparam int unsigned MAX_FRAME_BYTES = 10;
	localparam int unsigned WATCHDOG_CYCLES = 4000;
	localparam int unsigned DRAIN_CYCLES    = 16;

	// One decoded frame as it should appear on the output channel
	typedef struct {
		hsfd_pkg::cmd_t  command;
		logic [4:0]      gear_lights;
		logic            control_taken;
		logic [7:0]      steer_status;
		logic [15:0]     left_limit;
		logic [15:0]     right_limit;
		logic [15:0]     side_difference;
		logic [7:0]      direction;
		hsfd_pkg::save_t save_request;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  command;
	logic [4:0]  gear_lights;
	logic        control_taken;
	logic [7:0]  steer_status;
	logic [15:0] left_limit;
	logic [15:0] right_limit;
	logic [15:0] side_difference;
	logic [7:0]  direction;
	logic [1:0]  save_request;

	// Predicted framer and settings state
	logic        frame_open;
	int unsigned frame_fill;
	int unsigned frame_len_due;
	logic [7:0]  frame_buf [MAX_FRAME_BYTES];
	logic [4:0]  gear_q;
	logic        taken_q;
	logic [7:0]  steer_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic [15:0] diff_q;
	logic [7:0]  dir_q;

	frame_result_t frame_results_due[$];
	frame_result_t result_want;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned bytes_sent;
	int unsigned quiet_cycles;
	int unsigned failures = 0;

	helm_serial_frame_decoder #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) i_dut (.*);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_frame_buf();
		foreach (frame_buf[i]) frame_buf[i] = '0;
	endfunction

	// Recompute the absolute limit difference, floored at one
	function automatic void update_side_difference();
		logic [15:0] d;
		d = (left_q >= right_q) ? left_q - right_q : right_q - left_q;
		diff_q = (d == 16'd0) ? 16'd1 : d;
	endfunction

	// Advance the predicted state by one received byte; queue a result on frame end
	function automatic void decode_rx_byte(logic [7:0] value);
		frame_result_t r;
		logic [7:0]    b2;
		logic [7:0]    b3;
		logic [7:0]    offset;
		if (value == hsfd_pkg::START_BYTE && !frame_open) begin
			frame_fill = 0;
			frame_open = 1'b1;
			clear_frame_buf();
		end else if (value == hsfd_pkg::END_BYTE && frame_open &&
				frame_fill + 1 == frame_len_due) begin
			b2 = frame_buf[2];
			b3 = frame_buf[3];
			offset = frame_buf[1] - hsfd_pkg::CMD_BASE;
			r.command = hsfd_pkg::cmd_t'(offset[2:0]);
			r.save_request = hsfd_pkg::SAVE_NONE;
			frame_open = 1'b0;
			frame_fill = 0;
			frame_len_due = 0;
			case (r.command)
				hsfd_pkg::CMD_RESPOND: begin
					if (frame_buf[4][0]) begin
						taken_q = 1'b1;
						steer_q = b3;
						if (b2 >= hsfd_pkg::GEAR_MIN && b2 <= hsfd_pkg::GEAR_MAX)
							gear_q = 5'b00001 << (b2 - hsfd_pkg::GEAR_MIN);
					end else begin
						taken_q = 1'b0;
					end
				end
				hsfd_pkg::CMD_LEFT: begin
					left_q = {b2, b3};
					update_side_difference();
					r.save_request = hsfd_pkg::SAVE_LEFT;
				end
				hsfd_pkg::CMD_RIGHT: begin
					right_q = {b2, b3};
					update_side_difference();
					r.save_request = hsfd_pkg::SAVE_RIGHT;
				end
				hsfd_pkg::CMD_DIR: begin
					dir_q = b2;
					r.save_request = hsfd_pkg::SAVE_DIR;
				end
				default: begin
				end
			endcase
			clear_frame_buf();
			r.gear_lights     = gear_q;
			r.control_taken   = taken_q;
			r.steer_status    = steer_q;
			r.left_limit      = left_q;
			r.right_limit     = right_q;
			r.side_difference = diff_q;
			r.direction       = dir_q;
			frame_results_due.push_back(r);
		end

		// Store the byte while a frame is open; drop the frame when the buffer fills
		if (frame_open) begin
			if (frame_fill < MAX_FRAME_BYTES)
				frame_buf[frame_fill] = value;
			frame_fill++;
			if (frame_fill == 2 && frame_buf[1] >= hsfd_pkg::CMD_BASE &&
					frame_buf[1] <= hsfd_pkg::CMD_LAST)
				frame_len_due = hsfd_pkg::FRAME_LENGTH;
			if (frame_fill >= MAX_FRAME_BYTES) begin
				frame_fill = 0;
				frame_len_due = 0;
				frame_open = 1'b0;
				clear_frame_buf();
			end
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// Send one byte beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte  <= value;
		do @(posedge clk); while (!in_ready);
		decode_rx_byte(value);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] cmd_byte, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] end_byte);
		send_byte(hsfd_pkg::START_BYTE);
		send_byte(cmd_byte);
		send_byte(b2);
		send_byte(b3);
		send_byte(b4);
		send_byte(end_byte);
	endtask

	task automatic send_cmd_frame(input hsfd_pkg::cmd_t cmd, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4);
		send_frame(hsfd_pkg::CMD_BASE + 8'(cmd), b2, b3, b4, hsfd_pkg::END_BYTE);
	endtask

	// One well-formed frame of every command
	task automatic test_each_command();
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, 8'h03, 8'h80, 8'h01);
		send_cmd_frame(hsfd_pkg::CMD_CALIBRATE, 8'h55, 8'hAA, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_LEFT, 8'h12, 8'h34, 8'hFF);
		send_cmd_frame(hsfd_pkg::CMD_RIGHT, 8'h02, 8'h34, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_DIR, 8'hA5, 8'h00, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_TOUCH_RESET, 8'hFF, 8'hFF, 8'hFF);
	endtask

	// Full-scale and equal limits
	task automatic test_limit_extremes();
		send_cmd_frame(hsfd_pkg::CMD_LEFT, 8'hFF, 8'hFF, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_RIGHT, 8'h00, 8'h00, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_RIGHT, 8'hFF, 8'hFF, 8'h00);
		send_cmd_frame(hsfd_pkg::CMD_DIR, 8'h00, 8'hFF, 8'hFF);
	endtask

	// Gear codes at and outside the valid range, taken and not taken
	task automatic test_gear_codes();
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, hsfd_pkg::GEAR_MIN, 8'h00, 8'h01);
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, hsfd_pkg::GEAR_MAX, 8'hFF, 8'hFF);
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, 8'h00, 8'h11, 8'h01);
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, 8'h06, 8'h22, 8'h01);
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, 8'hFF, 8'h33, 8'h01);
		send_cmd_frame(hsfd_pkg::CMD_RESPOND, 8'h02, 8'h44, 8'hFE);
	endtask

	// Start byte inside a frame, unknown command, wrong end byte, stray bytes
	task automatic test_framing_cases();
		send_byte(hsfd_pkg::END_BYTE);
		send_byte(8'h00);
		send_frame(hsfd_pkg::CMD_BASE + 8'(hsfd_pkg::CMD_LEFT), hsfd_pkg::START_BYTE, 8'h10,
			hsfd_pkg::START_BYTE, hsfd_pkg::END_BYTE);
		send_frame(8'h46, 8'h00, 8'h00, 8'h00, hsfd_pkg::END_BYTE);
		repeat (4) send_byte(hsfd_pkg::END_BYTE);
		send_frame(hsfd_pkg::CMD_BASE + 8'(hsfd_pkg::CMD_DIR), 8'h77, 8'h00, 8'h00, 8'h00);
		repeat (4) send_byte(hsfd_pkg::END_BYTE);
		send_frame(hsfd_pkg::START_BYTE, 8'h01, 8'h02, 8'h03, hsfd_pkg::END_BYTE);
		repeat (4) send_byte(8'h3F);
		send_cmd_frame(hsfd_pkg::CMD_TOUCH_RESET, 8'h00, 8'h00, 8'h00);
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames
	task automatic test_random_stream(input int unsigned send_pct, input int unsigned stall_in,
			input int unsigned n_bytes);
		int unsigned    stop_at;
		int unsigned    pick;
		hsfd_pkg::cmd_t cmd;
		logic [7:0]     b2;
		logic [7:0]     b3;
		logic [7:0]     bad;
		send_idle_pct = send_pct;
		stall_pct = stall_in;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			cmd = hsfd_pkg::cmd_t'($urandom_range(5));
			b2 = 8'($urandom);
			b3 = 8'($urandom);
			if (cmd == hsfd_pkg::CMD_RESPOND && $urandom_range(1))
				b2 = 8'($urandom_range(6));
			// hit equal limits now and then
			if ((cmd == hsfd_pkg::CMD_RIGHT || cmd == hsfd_pkg::CMD_LEFT) &&
					$urandom_range(4) == 0)
				{b2, b3} = (cmd == hsfd_pkg::CMD_RIGHT) ? left_q : right_q;
			if (pick < 75) begin
				send_cmd_frame(cmd, b2, b3, 8'($urandom));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else if (pick < 92) begin
				do bad = 8'($urandom);
				while (bad >= hsfd_pkg::CMD_BASE && bad <= hsfd_pkg::CMD_LAST);
				send_frame(bad, b2, b3, 8'($urandom), hsfd_pkg::END_BYTE);
			end else begin
				do bad = 8'($urandom); while (bad == hsfd_pkg::END_BYTE);
				send_frame(hsfd_pkg::CMD_BASE + 8'(cmd), b2, b3, 8'($urandom), bad);
			end
		end
	endtask

	// Stall the output channel at random
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each result beat with the oldest predicted frame
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (frame_results_due.size() == 0) begin
				$error("result beat with no frame pending: command %0h", command);
				failures++;
			end else begin
				result_want = frame_results_due.pop_front();
				check_field("command", 16'(result_want.command), 16'(command));
				check_field("gear_lights", 16'(result_want.gear_lights), 16'(gear_lights));
				check_field("control_taken", 16'(result_want.control_taken), 16'(control_taken));
				check_field("steer_status", 16'(result_want.steer_status), 16'(steer_status));
				check_field("left_limit", result_want.left_limit, left_limit);
				check_field("right_limit", result_want.right_limit, right_limit);
				check_field("side_difference", result_want.side_difference, side_difference);
				check_field("direction", 16'(result_want.direction), 16'(direction));
				check_field("save_request", 16'(result_want.save_request), 16'(save_request));
			end
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("FAIL helm_serial_frame_decoder");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		send_idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		frame_open = 1'b0;
		frame_fill = 0;
		frame_len_due = 0;
		clear_frame_buf();
		gear_q = '0;
		taken_q = 1'b0;
		steer_q = '0;
		left_q = '0;
		right_q = '0;
		diff_q = 16'd1;
		dir_q = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_each_command();
		test_limit_extremes();
		test_gear_codes();
		test_framing_cases();
		test_random_stream(0, 0, 150);
		test_random_stream(53, 0, 150);
		test_random_stream(0, 53, 150);
		test_random_stream(11, 11, 150);

		// Drop valid and drain outstanding results
		@(negedge clk);
		in_valid <= 1'b0;
		stall_pct = 0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS helm_serial_frame_decoder");
		else
			$display("FAIL helm_serial_frame_decoder");
		$finish;
	end

endmodule
